/* rtl/core/slrq_pkg.sv */
// Shared constants and control types for the spectrum line resampler/quantizer.
// No dependencies.
`default_nettype none
package slrq_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_LINE_DEF  = 8192;
    localparam int RESULTS_CAP   = 64;
    localparam int LEVEL_W       = 8;
    localparam int COLUMN_W      = 12;
    localparam int SAMPLE_W      = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX  = 2'd3;

    localparam logic [13:0] LINE_LENGTH_RST = 14'd1024;
    localparam logic [12:0] OUT_WIDTH_RST   = 13'd1024;
    localparam logic [15:0] WINDOW_MIN_RST  = 16'hC400;
    localparam logic [15:0] WINDOW_MAX_RST  = 16'h0000;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    typedef struct packed {
        logic accept;
        logic prep;
        logic mul;
        logic qset;
        logic div_step;
        logic emit;
        logic skip;
        logic finish;
    } slrq_cmd_t;

    typedef struct packed {
        logic mode_eq;
        logic mode_dn;
        logic dn_hit;
        logic up_more;
        logic cap_hit;
        logic out_free;
    } slrq_stat_t;

endpackage
`default_nettype wire

/* rtl/core/slrq_ctrl.sv */
// Sequencing state machine for the resampler/quantizer.
// Depends on slrq_pkg; drives the datapath slrq_dp by command struct.
`default_nettype none
module slrq_ctrl
    import slrq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire slrq_stat_t stat,
    output slrq_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_QSET  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_UPCHK = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.mode_eq || (stat.mode_dn && stat.dn_hit)
                    || (!stat.mode_dn && stat.up_more))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_QSET;
            end
            S_QSET:
            begin
                cmd.qset     = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'd7)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.mode_eq || stat.mode_dn)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_UPCHK;
                    end
                end
            end
            S_UPCHK:
            begin
                if (stat.up_more)
                begin
                    if (stat.cap_hit)
                    begin
                        cmd.skip = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/slrq_dp.sv */
// Datapath: configuration registers, line counters, bin accumulator, edge
// multipliers, quantizer with 8-step restoring divider and output register.
// Depends on slrq_pkg; commanded by slrq_ctrl.
`default_nettype none
module slrq_dp
    import slrq_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_LINE  = MAX_LINE_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [15:0]                 cfg_data,
    input  wire logic signed [SAMPLE_W-1:0]  sample_db,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [LEVEL_W-1:0]               level,
    output logic [COLUMN_W-1:0]              column,
    output logic                             line_end,
    input  wire slrq_cmd_t                   cmd,
    output slrq_stat_t                       stat
);

    localparam int LINE_W = $clog2(MAX_LINE + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int SUM_W  = LINE_W + SAMPLE_W;
    localparam int PW     = LINE_W + COL_W + 1;
    localparam int WW     = LINE_W + 18;
    localparam int NUM_W  = WW + 11;
    localparam int CAP_W  = $clog2(RESULTS_CAP + 1);

    logic [13:0] line_length_reg;
    logic [12:0] out_width_reg;
    logic signed [15:0] window_min_reg;
    logic signed [15:0] window_max_reg;

    logic [LINE_W-1:0] sample_index_reg;
    logic [COL_W-1:0]  column_index_reg;
    logic signed [SUM_W-1:0] bin_sum_reg;
    logic [LINE_W-1:0] bin_count_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic [PW-1:0] ma_reg;
    logic [PW-1:0] mb_reg;
    logic signed [SUM_W-1:0] qsum_reg;
    logic [LINE_W-1:0] qcnt_reg;
    logic signed [WW-1:0] p_lo_reg, p_hi_reg, p_rng_reg;
    logic le_reg, ge_reg;
    logic [NUM_W-1:0] rem_reg, dsh_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic [CAP_W-1:0] k_reg;

    logic out_valid_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [COLUMN_W-1:0] column_reg;
    logic line_end_reg;

    logic [31:0] len32, w32;
    logic [LINE_W-1:0] len;
    logic [COL_W-1:0] w;
    logic last;
    logic out_free;
    logic [LEVEL_W-1:0] level_val;
    logic [COL_W-1:0] col_sel;
    logic signed [WW-1:0] cnt_ext, lo_ext, hi_ext, rng_ext, sum_ext;
    logic signed [WW:0] diff;
    logic [NUM_W-1:0] diff_u;

    always_comb
    begin
        len32 = 32'(line_length_reg);
        if (len32 == 32'd0)
        begin
            len32 = 32'd1;
        end
        else if (len32 > 32'(MAX_LINE))
        begin
            len32 = 32'(MAX_LINE);
        end
        w32 = 32'(out_width_reg);
        if (w32 == 32'd0)
        begin
            w32 = 32'd1;
        end
        else if (w32 > 32'(MAX_WIDTH))
        begin
            w32 = 32'(MAX_WIDTH);
        end
    end

    assign len  = LINE_W'(len32);
    assign w    = COL_W'(w32);
    assign last = ((LINE_W + 1)'(sample_index_reg) + (LINE_W + 1)'(1))
                  >= (LINE_W + 1)'(len);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.mode_eq  = (32'(len) == 32'(w));
    assign stat.mode_dn  = (32'(len) > 32'(w));
    assign stat.dn_hit   = (ma_reg < mb_reg) || last;
    assign stat.up_more  = (column_index_reg < w) && (ma_reg < mb_reg);
    assign stat.cap_hit  = (k_reg == CAP_W'(RESULTS_CAP));
    assign stat.out_free = out_free;

    // pass-through columns follow the sample index
    assign col_sel = stat.mode_eq ? COL_W'(sample_index_reg) : column_index_reg;

    assign cnt_ext = WW'({1'b0, qcnt_reg});
    assign lo_ext  = WW'(window_min_reg);
    assign hi_ext  = WW'(window_max_reg);
    assign rng_ext = hi_ext - lo_ext;
    assign sum_ext = WW'(qsum_reg);
    assign diff    = (WW + 1)'(sum_ext) - (WW + 1)'(p_lo_reg);
    assign diff_u  = NUM_W'(diff);

    assign level_val = le_reg ? '0 : (ge_reg ? LEVEL_MAX : q_reg);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LENGTH_RST;
            out_width_reg   <= OUT_WIDTH_RST;
            window_min_reg  <= WINDOW_MIN_RST;
            window_max_reg  <= WINDOW_MAX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_LENGTH: line_length_reg <= cfg_data[13:0];
                REG_OUT_WIDTH:   out_width_reg   <= cfg_data[12:0];
                REG_WINDOW_MIN:  window_min_reg  <= cfg_data;
                REG_WINDOW_MAX:  window_max_reg  <= cfg_data;
                default:         line_length_reg <= line_length_reg;
            endcase
        end
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            column_index_reg <= '0;
            bin_sum_reg      <= '0;
            bin_count_reg    <= '0;
            k_reg            <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                k_reg <= '0;
                if (sample_index_reg >= len || column_index_reg >= w)
                begin
                    sample_index_reg <= '0;
                    column_index_reg <= '0;
                    bin_sum_reg      <= '0;
                    bin_count_reg    <= '0;
                end
            end
            if (cmd.prep && stat.mode_dn)
            begin
                bin_sum_reg   <= bin_sum_reg + SUM_W'(s_reg);
                bin_count_reg <= bin_count_reg + LINE_W'(1);
            end
            if (cmd.emit)
            begin
                k_reg <= k_reg + CAP_W'(1);
                if (stat.mode_eq)
                begin
                    column_index_reg <= COL_W'(32'(sample_index_reg) + 32'd1);
                end
                else
                begin
                    column_index_reg <= column_index_reg + COL_W'(1);
                end
                if (stat.mode_dn)
                begin
                    bin_sum_reg   <= '0;
                    bin_count_reg <= '0;
                end
            end
            if (cmd.skip)
            begin
                column_index_reg <= column_index_reg + COL_W'(1);
            end
            if (cmd.finish)
            begin
                if (last)
                begin
                    sample_index_reg <= '0;
                    column_index_reg <= '0;
                    bin_sum_reg      <= '0;
                    bin_count_reg    <= '0;
                end
                else
                begin
                    sample_index_reg <= sample_index_reg + LINE_W'(1);
                end
            end
        end
    end

    // edge products and quantizer
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s_reg <= sample_db;
        end
        if (cmd.prep)
        begin
            if (stat.mode_dn)
            begin
                ma_reg   <= (PW'(column_index_reg) + PW'(1)) * PW'(len);
                mb_reg   <= (PW'(sample_index_reg) + PW'(2)) * PW'(w);
                qsum_reg <= bin_sum_reg + SUM_W'(s_reg);
                qcnt_reg <= bin_count_reg + LINE_W'(1);
            end
            else
            begin
                ma_reg   <= PW'(column_index_reg) * PW'(len);
                mb_reg   <= (PW'(sample_index_reg) + PW'(1)) * PW'(w);
                qsum_reg <= SUM_W'(s_reg);
                qcnt_reg <= LINE_W'(1);
            end
        end
        if ((cmd.emit && !stat.mode_eq && !stat.mode_dn) || cmd.skip)
        begin
            ma_reg <= ma_reg + PW'(len);
        end
        if (cmd.mul)
        begin
            p_lo_reg  <= cnt_ext * lo_ext;
            p_hi_reg  <= cnt_ext * hi_ext;
            p_rng_reg <= cnt_ext * rng_ext;
        end
        if (cmd.qset)
        begin
            le_reg  <= (sum_ext <= p_lo_reg);
            ge_reg  <= (sum_ext >= p_hi_reg);
            rem_reg <= (diff_u << 9) - (diff_u << 1) + NUM_W'(p_rng_reg);
            dsh_reg <= NUM_W'(p_rng_reg) << 8;
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[LEVEL_W-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[LEVEL_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            level_reg    <= level_val;
            column_reg   <= COLUMN_W'(col_sel);
            line_end_reg <= ((32'(col_sel) + 32'd1) == 32'(w));
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign column    = column_reg;
    assign line_end  = line_end_reg;

endmodule
`default_nettype wire

/* rtl/core/spectrum_line_resample_quantize.sv */
// Top level: spectrum line resampler and 8-bit quantizer.
// A sample is taken only in idle, and a new one waits until the last has emitted all of
// its columns; an upsampled sample emits its columns one by one, skipping any beyond 64.
// Column levels come from the 8-step restoring divider of the quantizer, and emission
// stalls while the receiver holds the output register.
// Reset: configuration to defaults, line counters and bin to zero, no clearing pass.
`default_nettype none
module spectrum_line_resample_quantize
    import slrq_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_LINE  = MAX_LINE_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [15:0]                 cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  sample_db,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [LEVEL_W-1:0]               level,
    output logic [COLUMN_W-1:0]              column,
    output logic                             line_end
);

    slrq_cmd_t  cmd;
    slrq_stat_t stat;

    assign cfg_ready = 1'b1;

    slrq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    slrq_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINE  (MAX_LINE)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_db (sample_db),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .level     (level),
        .column    (column),
        .line_end  (line_end),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

/* bench/slrq_checker.sv */
`timescale 1ns / 100ps
// Checker for spectrum_line_resample_quantize: watches the config, sample and column channels.
// It predicts the expected columns, compares them with the block's output and counts mismatches.
// Depends on slrq_pkg.
module slrq_checker
    import slrq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_db,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [LEVEL_W-1:0]         level,
    input  logic [COLUMN_W-1:0]        column,
    input  logic                       line_end,
    output int                         errors,
    output int                         pending
);

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [COLUMN_W-1:0] column;
        logic                line_end;
    } column_t;

    column_t col_q[$];

    logic [13:0]        line_len;
    logic [12:0]        disp_width;
    logic signed [15:0] win_lo;
    logic signed [15:0] win_hi;

    longint samp_idx, col_idx, bin_sum, bin_cnt;

    assign pending = col_q.size();

    function automatic logic [7:0] quantise(longint sum, longint cnt);
        longint lo, hi, range;
        lo = win_lo;
        hi = win_hi;
        if (sum <= cnt * lo)
        begin
            return 8'd0;
        end
        if (sum >= cnt * hi)
        begin
            return LEVEL_MAX;
        end
        range = hi - lo;
        return 8'((((sum - cnt * lo) * 510) + cnt * range) / (2 * cnt * range));
    endfunction

    task automatic push_column(logic [7:0] lv, longint c, longint w);
        column_t e;
        e.level    = lv;
        e.column   = COLUMN_W'(c);
        e.line_end = (c + 1 == w);
        col_q.insert(col_q.size(), e);
    endtask

    task automatic clear_line();
        samp_idx = 0;
        col_idx  = 0;
        bin_sum  = 0;
        bin_cnt  = 0;
    endtask

    task automatic predict_sample(logic signed [15:0] smp);
        longint len, w, n, s, edge_pos, c, lim;
        int k;
        bit last;
        len = line_len;
        w   = disp_width;
        s   = smp;
        if (len == 0) len = 1;
        if (len > MAX_LINE_DEF) len = MAX_LINE_DEF;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (samp_idx >= len || col_idx >= w) clear_line();
        n = samp_idx;
        last = (n + 1 >= len);
        if (len == w)
        begin
            push_column(quantise(s, 1), n, w);
            col_idx = n + 1;
        end
        else if (len > w)
        begin
            bin_sum += s;
            bin_cnt++;
            edge_pos = ((col_idx + 1) * len) / w;
            if (n + 1 >= edge_pos || last)
            begin
                push_column(quantise(bin_sum, bin_cnt), col_idx, w);
                col_idx++;
                bin_sum = 0;
                bin_cnt = 0;
            end
        end
        else
        begin
            c   = col_idx;
            lim = (n + 1) * w;
            k   = 0;
            while (c < w && c * len < lim)
            begin
                if (k < RESULTS_CAP)
                begin
                    push_column(quantise(s, 1), c, w);
                    k++;
                end
                c++;
            end
            col_idx = c;
        end
        if (last) clear_line();
        else samp_idx = n + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        column_t exp_col;
        if (!rst_n)
        begin
            line_len   = LINE_LENGTH_RST;
            disp_width = OUT_WIDTH_RST;
            win_lo     = WINDOW_MIN_RST;
            win_hi     = WINDOW_MAX_RST;
            clear_line();
            col_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LINE_LENGTH: line_len   = cfg_data[13:0];
                    REG_OUT_WIDTH:   disp_width = cfg_data[12:0];
                    REG_WINDOW_MIN:  win_lo     = cfg_data;
                    REG_WINDOW_MAX:  win_hi     = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_sample(sample_db);
            if (out_valid && out_ready)
            begin
                if (col_q.size() == 0)
                begin
                    $display("%0t: unexpected column request: level %0d column %0d end %0b",
                             $time, level, column, line_end);
                    errors++;
                end
                else
                begin
                    exp_col = col_q.pop_front();
                    if (exp_col.level !== level)
                    begin
                        $display("%0t: level mismatch: expected %0d actual %0d",
                                 $time, exp_col.level, level);
                        errors++;
                    end
                    if (exp_col.column !== column)
                    begin
                        $display("%0t: column mismatch: expected %0d actual %0d",
                                 $time, exp_col.column, column);
                        errors++;
                    end
                    if (exp_col.line_end !== line_end)
                    begin
                        $display("%0t: line_end mismatch: expected %0b actual %0b",
                                 $time, exp_col.line_end, line_end);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_spectrum_line_resample_quantize.sv */
`timescale 1ns / 100ps
// Testbench top for spectrum_line_resample_quantize: clock, reset, stimulus and verdict.
// Depends on slrq_pkg, the block and slrq_checker.
module tb_spectrum_line_resample_quantize;
    import slrq_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 4400;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [15:0]                cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_db;
    logic                       out_valid;
    logic                       out_ready;
    logic [LEVEL_W-1:0]         level;
    logic [COLUMN_W-1:0]        column;
    logic                       line_end;

    int errors;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_go;
    int hold_left;
    int cycles;

    spectrum_line_resample_quantize dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample_db(sample_db),
        .out_valid(out_valid), .out_ready(out_ready),
        .level(level), .column(column), .line_end(line_end)
    );

    slrq_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample_db(sample_db),
        .out_valid(out_valid), .out_ready(out_ready),
        .level(level), .column(column), .line_end(line_end),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_go && hold_left == 0)
        begin
            hold_left = 400;
            hold_go = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_line(logic [15:0] len, logic [15:0] w, logic [15:0] lo, logic [15:0] hi);
        wait_idle();
        write_reg(REG_LINE_LENGTH, len);
        write_reg(REG_OUT_WIDTH, w);
        write_reg(REG_WINDOW_MIN, lo);
        write_reg(REG_WINDOW_MAX, hi);
    endtask

    task automatic send_sample(logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_db <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        int lo, hi, len, w;
        logic [15:0] v;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_db = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b0;
        hold_left = 0;
        cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through, default window: extremes and window edges
        set_line(16'd6, 16'd6, 16'hC400, 16'h0000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hC400);
        send_sample(16'h0000);
        send_sample(16'hE200);
        send_sample(16'hC401);
        // averaging
        set_line(16'd8, 16'd3, 16'hF000, 16'h1000);
        for (int i = 0; i < 8; i++) send_sample(16'($urandom));
        // upsampling, reversed window
        set_line(16'd2, 16'd7, 16'h1000, 16'hF000);
        send_sample(16'h1001);
        send_sample(16'h1000);
        // too many columns, saturated width
        set_line(16'd1, 16'hFFFF, 16'h8000, 16'h7FFF);
        send_sample(16'h0000);
        // zero length and width, empty window
        set_line(16'h0000, 16'h0000, 16'h0100, 16'h0100);
        send_sample(16'h0101);
        send_sample(16'h0100);
        // saturated length
        set_line(16'hFFFF, 16'd4096, 16'h8000, 16'h7FFF);
        for (int i = 0; i < 3; i++) send_sample(16'($urandom));

        for (int i = 0; i < 90; i++)
        begin
            if (i % 15 == 0)
            begin
                lo = $urandom_range(30000) - 30000;
                hi = lo + $urandom_range(35000);
                if ($urandom_range(5) == 0) hi = lo - $urandom_range(200);
                if (hi > 32767) hi = 32767;
                if ($urandom_range(4) == 0)
                begin
                    len = 1;
                    w = $urandom_range(64, 120);
                end
                else
                begin
                    len = $urandom_range(1, 24);
                    w = $urandom_range(1, 24);
                end
                set_line(16'(len), 16'(w), 16'(lo), 16'(hi));
                if (i == 30) hold_go = 1'b1;
            end
            if (i < 30)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 46;
            end
            else if (i < 60)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(3) == 0)
                v = 16'($urandom);
            else
                v = 16'(lo + int'($urandom_range(40000)) - 2000);
            send_sample(v);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
